FILE: hdl/pca_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pca_pkg
// Shared constants, types and helpers of the pixel color adjust pipeline.
// ----------------------------------------------------------------------------
package pca_pkg;

	localparam int FRAC_BITS = 12;
	localparam int ONE       = 1 << FRAC_BITS;
	localparam int HALF      = 1 << (FRAC_BITS - 1);
	localparam int VW        = FRAC_BITS + 5;        // signed Q5.F working width
	localparam int FX_MAX    = 16 * ONE - 1;
	localparam int FX_MIN    = -16 * ONE;
	localparam int W_RED     = (299 * ONE + 500) / 1000;
	localparam int W_BLUE    = (114 * ONE + 500) / 1000;
	localparam int W_GREEN   = ONE - W_RED - W_BLUE;
	localparam int EPS_RAW   = (ONE + 500) / 1000;
	localparam int EPS       = (EPS_RAW > 0) ? EPS_RAW : 1;
	localparam int DEN_W     = VW - 1;               // divisor is positive
	localparam int DVD_W     = VW + FRAC_BITS;       // |ease| << F
	localparam int WID       = 48;

	typedef logic signed [VW-1:0]  fx_t;
	typedef logic signed [WID-1:0] wide_t;
	typedef logic signed [FRAC_BITS+1:0] wgt_t;

	localparam wgt_t WR_C = wgt_t'(W_RED);
	localparam wgt_t WG_C = wgt_t'(W_GREEN);
	localparam wgt_t WB_C = wgt_t'(W_BLUE);

	typedef enum logic [1:0] {
		REG_BRIGHTNESS = 2'd0,
		REG_CONTRAST   = 2'd1,
		REG_SATURATION = 2'd2,
		REG_CURVE      = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic             neg;
		logic [DVD_W-1:0] dvd;
		logic [DEN_W-1:0] den;
	} div_in_t;

	typedef struct packed {
		logic             neg;
		logic [DVD_W-1:0] quo;
	} div_out_t;

	function automatic fx_t fx_sat(input wide_t v);
		fx_t r;
		if (v > wide_t'(FX_MAX)) begin
			r = fx_t'(FX_MAX);
		end else if (v < wide_t'(FX_MIN)) begin
			r = fx_t'(FX_MIN);
		end else begin
			r = v[VW-1:0];
		end
		return r;
	endfunction

	// clamp to 0..1, then floor(v * 255)
	function automatic logic [7:0] to_byte(input fx_t v);
		logic [FRAC_BITS:0]   t;
		logic [FRAC_BITS+8:0] p;
		if (v < 0) begin
			t = '0;
		end else if (v > fx_t'(ONE)) begin
			t = (FRAC_BITS+1)'(ONE);
		end else begin
			t = v[FRAC_BITS:0];
		end
		p = (FRAC_BITS+9)'(t) * (FRAC_BITS+9)'(255);
		return p[FRAC_BITS+7:FRAC_BITS];
	endfunction

endpackage

FILE: hdl/pca_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pca_div
// Pipelined restoring divider, one quotient bit per stage, unsigned
// magnitude with the sign carried alongside.
// ----------------------------------------------------------------------------
module pca_div (
	input  logic              clk,
	input  logic              en,
	input  pca_pkg::div_in_t  din,
	output pca_pkg::div_out_t dout
);

	localparam int N  = pca_pkg::DVD_W;
	localparam int DW = pca_pkg::DEN_W;

	logic [DW-1:0] rem_s [N];
	logic [N-1:0]  dvd_s [N];
	logic [N-1:0]  quo_s [N];
	logic [DW-1:0] den_s [N];
	logic          neg_s [N];

	logic [DW-1:0] rem_p [N];
	logic [N-1:0]  dvd_p [N];
	logic [N-1:0]  quo_p [N];
	logic [DW-1:0] den_p [N];
	logic          neg_p [N];
	logic [DW:0]   trial [N];
	logic [N-1:0]  ge;

	for (genvar k = 0; k < N; k++) begin : g_stage
		if (k == 0) begin : g_first
			assign rem_p[k] = '0;
			assign dvd_p[k] = din.dvd;
			assign quo_p[k] = '0;
			assign den_p[k] = din.den;
			assign neg_p[k] = din.neg;
		end else begin : g_next
			assign rem_p[k] = rem_s[k-1];
			assign dvd_p[k] = dvd_s[k-1];
			assign quo_p[k] = quo_s[k-1];
			assign den_p[k] = den_s[k-1];
			assign neg_p[k] = neg_s[k-1];
		end

		assign trial[k] = {rem_p[k], dvd_p[k][N-1]};
		assign ge[k]    = (trial[k] >= {1'b0, den_p[k]});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge[k] ? DW'(trial[k] - {1'b0, den_p[k]}) : trial[k][DW-1:0];
				dvd_s[k] <= dvd_p[k] << 1;
				quo_s[k] <= {quo_p[k][N-2:0], ge[k]};
				den_s[k] <= den_p[k];
				neg_s[k] <= neg_p[k];
			end
		end
	end

	assign dout.neg = neg_s[N-1];
	assign dout.quo = quo_s[N-1];

endmodule

FILE: hdl/pixel_color_adjust.sv
`timescale 1ns / 1ps
// Pipeline: 10 arithmetic stages, 29 divider stages and 4 tail stages lie between an
// accepted input word and its output word.
// Throughput: one pixel per clock while the output is not stalled; the one-bit-per-stage
// divider pipeline sets the depth, not the rate. A stall at the output freezes every stage.
// Reset: arst_n clears all valid bits and loads the registers with
// brightness 0, contrast 1.0, saturation 1.0, curve off.
// ----------------------------------------------------------------------------
// pixel_color_adjust
// Contrast, brightness, saturation and luminance curve on one RGB pixel.
// ----------------------------------------------------------------------------
module pixel_color_adjust (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [14:0] cfg_wdata,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // red_in[12:0], green_in[25:13], blue_in[38:26], zero pad
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // red_out[7:0], green_out[15:8], blue_out[23:16]
);

	localparam int F  = pca_pkg::FRAC_BITS;
	localparam int VW = pca_pkg::VW;
	localparam int ND = pca_pkg::DVD_W;

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic signed [13:0] brightness_q;
	logic        [14:0] contrast_q;
	logic        [14:0] saturation_q;
	logic               curve_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brightness_q <= '0;
			contrast_q   <= 15'(pca_pkg::ONE);
			saturation_q <= 15'(pca_pkg::ONE);
			curve_q      <= 1'b0;
		end else if (cfg_we) begin
			unique case (pca_pkg::cfg_reg_t'(cfg_addr))
				pca_pkg::REG_BRIGHTNESS: brightness_q <= cfg_wdata[13:0];
				pca_pkg::REG_CONTRAST:   contrast_q   <= cfg_wdata;
				pca_pkg::REG_SATURATION: saturation_q <= cfg_wdata;
				pca_pkg::REG_CURVE:      curve_q      <= cfg_wdata[0];
			endcase
		end
	end

	// ------------------------------------------------------------------
	// flow control: the whole pipe moves unless the output word is held
	// ------------------------------------------------------------------
	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic [ND-1:0] v_dv;
	logic v_sc, v_mu, v_c3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5} <= '0;
			{v_s6, v_s7, v_s8, v_s9, v_s10} <= '0;
			v_dv     <= '0;
			v_sc     <= 1'b0;
			v_mu     <= 1'b0;
			v_c3     <= 1'b0;
			m_tvalid <= 1'b0;
		end else if (en) begin
			v_s1     <= s_tvalid;
			v_s2     <= v_s1;
			v_s3     <= v_s2;
			v_s4     <= v_s3;
			v_s5     <= v_s4;
			v_s6     <= v_s5;
			v_s7     <= v_s6;
			v_s8     <= v_s7;
			v_s9     <= v_s8;
			v_s10    <= v_s9;
			v_dv     <= {v_dv[ND-2:0], v_s10};
			v_sc     <= v_dv[ND-1];
			v_mu     <= v_sc;
			v_c3     <= v_mu;
			m_tvalid <= v_c3;
		end
	end

	// ------------------------------------------------------------------
	// S1: (x - 0.5) * contrast
	// ------------------------------------------------------------------
	logic [12:0] x_in [3];
	assign x_in[0] = s_tdata[12:0];
	assign x_in[1] = s_tdata[25:13];
	assign x_in[2] = s_tdata[38:26];

	localparam logic signed [14:0] HALF15 = 15'(pca_pkg::HALF);

	logic signed [14:0] xm [3];
	logic signed [30:0] p_s1 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			xm[i] = $signed({2'b00, x_in[i]}) - HALF15;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				p_s1[i] <= xm[i] * $signed({1'b0, contrast_q});
			end
		end
	end

	// S2: floor shift, + 0.5 + brightness, saturate
	pca_pkg::fx_t c_s2 [3];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				c_s2[i] <= pca_pkg::fx_sat(pca_pkg::wide_t'(p_s1[i] >>> F)
					+ pca_pkg::wide_t'(pca_pkg::HALF)
					+ pca_pkg::wide_t'(brightness_q));
			end
		end
	end

	// S3: luma weight products
	logic signed [VW+F+1:0] lw_s3 [3];
	pca_pkg::fx_t           c_s3 [3];
	always_ff @(posedge clk) begin
		if (en) begin
			lw_s3[0] <= c_s2[0] * pca_pkg::WR_C;
			lw_s3[1] <= c_s2[1] * pca_pkg::WG_C;
			lw_s3[2] <= c_s2[2] * pca_pkg::WB_C;
			c_s3     <= c_s2;
		end
	end

	// S4: gray = sat(sum >> F)
	pca_pkg::fx_t gray_s4;
	pca_pkg::fx_t c_s4 [3];
	always_ff @(posedge clk) begin
		if (en) begin
			gray_s4 <= pca_pkg::fx_sat((pca_pkg::wide_t'(lw_s3[0]) + pca_pkg::wide_t'(lw_s3[1])
				+ pca_pkg::wide_t'(lw_s3[2])) >>> F);
			c_s4    <= c_s3;
		end
	end

	// S5: (c - gray) * saturation
	logic signed [VW:0]    dg [3];
	logic signed [VW+16:0] ps_s5 [3];
	pca_pkg::fx_t          gray_s5;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dg[i] = (VW+1)'(c_s4[i]) - (VW+1)'(gray_s4);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				ps_s5[i] <= dg[i] * $signed({1'b0, saturation_q});
			end
			gray_s5 <= gray_s4;
		end
	end

	// S6: blended color
	pca_pkg::fx_t c2_s6 [3];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				c2_s6[i] <= pca_pkg::fx_sat(pca_pkg::wide_t'(gray_s5)
					+ pca_pkg::wide_t'(ps_s5[i] >>> F));
			end
		end
	end

	// S7/S8: luma of the blended color
	logic signed [VW+F+1:0] lw_s7 [3];
	pca_pkg::fx_t           c2_s7 [3];
	pca_pkg::fx_t           lum_s8;
	pca_pkg::fx_t           c2_s8 [3];
	always_ff @(posedge clk) begin
		if (en) begin
			lw_s7[0] <= c2_s6[0] * pca_pkg::WR_C;
			lw_s7[1] <= c2_s6[1] * pca_pkg::WG_C;
			lw_s7[2] <= c2_s6[2] * pca_pkg::WB_C;
			c2_s7    <= c2_s6;
			lum_s8   <= pca_pkg::fx_sat((pca_pkg::wide_t'(lw_s7[0]) + pca_pkg::wide_t'(lw_s7[1])
				+ pca_pkg::wide_t'(lw_s7[2])) >>> F);
			c2_s8    <= c2_s7;
		end
	end

	// S9: ease square; lower half squares lum, upper half squares (1 - lum)
	logic                       lo;
	logic signed [VW:0]         mbase;
	logic signed [2*VW+1:0]     sq_s9;
	logic                       lo_s9;
	logic [pca_pkg::DEN_W-1:0]  den_s9;
	pca_pkg::fx_t               c2_s9 [3];

	assign lo    = (lum_s8 < pca_pkg::fx_t'(pca_pkg::HALF));
	assign mbase = lo ? (VW+1)'(lum_s8) : ((VW+1)'(pca_pkg::ONE) - (VW+1)'(lum_s8));

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s9  <= mbase * mbase;
			lo_s9  <= lo;
			// divisor floor for negative or tiny luma
			den_s9 <= (lum_s8 > pca_pkg::fx_t'(pca_pkg::EPS)) ? lum_s8[pca_pkg::DEN_W-1:0]
				: pca_pkg::DEN_W'(pca_pkg::EPS);
			c2_s9  <= c2_s8;
		end
	end

	// S10: ease value
	pca_pkg::wide_t e2;
	pca_pkg::fx_t   ease_s10;
	pca_pkg::fx_t   c2_s10 [3];
	logic [pca_pkg::DEN_W-1:0] den_s10;

	assign e2 = (pca_pkg::wide_t'(sq_s9) <<< 1) >>> F;

	always_ff @(posedge clk) begin
		if (en) begin
			ease_s10 <= lo_s9 ? pca_pkg::fx_sat(e2)
				: pca_pkg::fx_sat(pca_pkg::wide_t'(pca_pkg::ONE) - e2);
			den_s10  <= den_s9;
			c2_s10   <= c2_s9;
		end
	end

	// ------------------------------------------------------------------
	// divider: scale = (ease << F) / den, truncated toward zero
	// ------------------------------------------------------------------
	pca_pkg::div_in_t  div_in;
	pca_pkg::div_out_t div_out;
	logic [VW-1:0]     ease_mag;

	// -(-16.0) wraps to the same pattern, read as unsigned magnitude
	assign ease_mag   = ease_s10[VW-1] ? VW'(-ease_s10) : VW'(ease_s10);
	assign div_in.neg = ease_s10[VW-1];
	assign div_in.dvd = {ease_mag, {F{1'b0}}};
	assign div_in.den = den_s10;

	pca_div u_div (
		.clk  (clk),
		.en   (en),
		.din  (div_in),
		.dout (div_out)
	);

	// color travels beside the divider
	pca_pkg::fx_t c2_dv [ND][3];
	always_ff @(posedge clk) begin
		if (en) begin
			c2_dv[0] <= c2_s10;
			for (int k = 1; k < ND; k++) begin
				c2_dv[k] <= c2_dv[k-1];
			end
		end
	end

	// SC: signed scale
	logic signed [ND:0] scale_sc;
	pca_pkg::fx_t       c2_sc [3];
	always_ff @(posedge clk) begin
		if (en) begin
			scale_sc <= div_out.neg ? -$signed({1'b0, div_out.quo}) : $signed({1'b0, div_out.quo});
			c2_sc    <= c2_dv[ND-1];
		end
	end

	// MU: color * scale
	logic signed [VW+ND:0] pm_mu [3];
	pca_pkg::fx_t          c2_mu [3];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pm_mu[i] <= c2_sc[i] * scale_sc;
			end
			c2_mu <= c2_sc;
		end
	end

	// C3: curve result or bypass
	pca_pkg::fx_t c3_s [3];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				c3_s[i] <= curve_q ? pca_pkg::fx_sat(pca_pkg::wide_t'(pm_mu[i] >>> F)) : c2_mu[i];
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= {pca_pkg::to_byte(c3_s[2]), pca_pkg::to_byte(c3_s[1]),
				pca_pkg::to_byte(c3_s[0])};
		end
	end

`ifndef ASSERT_OFF
	// divider never sees a zero divisor
	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s10 |-> (den_s10 != '0))
		else $error("divisor below floor");

	// a held output word freezes the valid bits v_s1, v_s5, v_s10, v_dv, v_sc, v_mu and v_c3
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> $stable({v_s1, v_s5, v_s10, v_dv, v_sc, v_mu, v_c3}))
		else $error("pipe moved during stall");

	// an accepted word enters the first stage
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> v_s1)
		else $error("accepted word lost");
`endif

endmodule
